@@ sv/vertex_transform_4x4_top_defines.svh @@
// Assertion macros for the vertex transform checker.
// No dependencies; included by the checker file.
`ifndef VERTEX_TRANSFORM_4X4_TOP_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_TOP_DEFINES_SVH

// same-cycle implication
`define VT4_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VT4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vt4_pkg.sv @@
// Shared types, constants and helper functions for the vertex transform.
// No dependencies.
package vt4_pkg;

	localparam int NREGS     = 8;
	localparam int IDX_W     = 4;
	localparam int QBITS     = 48;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;
	localparam int SUM_W     = 66;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	localparam logic [63:0] RST_ROW1_LO = 64'h0000_0000_0001_0000;
	localparam logic [63:0] RST_ROW2_LO = 64'h0001_0000_0000_0000;
	localparam logic [63:0] RST_ROW3_HI = 64'h0000_0000_0001_0000;
	localparam logic [63:0] RST_ROW4_HI = 64'h0001_0000_0000_0000;

	typedef enum logic {
		CMD_PLAIN  = 1'b0,
		CMD_DIVIDE = 1'b1
	} cmd_t;

	typedef logic [NREGS-1:0][63:0] mat_t;

	typedef struct packed {
		cmd_t               cmd;
		logic               sat;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic signed [31:0] mat_entry(input mat_t m, input int r, input int c);
		logic [63:0] rv;
		rv = m[r*2 + c/2];
		return (c % 2 == 1) ? rv[63:32] : rv[31:0];
	endfunction

	// Q34.32 sum to Q16.16: truncate toward zero, saturate
	function automatic logic [32:0] narrow(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] adj;
		logic signed [SUM_W-17:0] t;
		adj = s[SUM_W-1] ? s + SUM_W'(16'hFFFF) : s;
		t = adj[SUM_W-1:16];
		if (t > (SUM_W-16)'(Q_MAX))
			return {1'b1, Q_MAX};
		else if (t < -(SUM_W-16)'(64'sh8000_0000))
			return {1'b1, Q_MIN};
		else
			return {1'b0, t[31:0]};
	endfunction

endpackage

@@ sv/vt4_front.sv @@
// Front part: input register, twelve products, column sums, narrowing.
// Depends on vt4_pkg; pushes items into vt4_queue.
module vt4_front (
	input  logic                clk,
	input  logic                arst_n,
	input  vt4_pkg::mat_t       mat,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic signed [31:0]  x_in,
	input  logic signed [31:0]  y_in,
	input  logic signed [31:0]  z_in,
	input  vt4_pkg::q_stat_t    q_stat,
	output logic                push,
	output vt4_pkg::item_t      push_item
);
	import vt4_pkg::*;

	logic                       en;
	logic                       v_s1, v_s2, v_s3;
	cmd_t                       cmd_s1, cmd_s2, cmd_s3;
	logic signed [2:0][31:0]    p_s1;
	logic signed [63:0]         prod_s2 [3][4];
	logic signed [31:0]         tr_s2   [4];
	logic signed [SUM_W-1:0]    sum_s3  [4];
	logic [32:0]                nr      [4];

	assign en       = !q_stat.full;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(command);
			p_s1   <= {z_in, y_in, x_in};
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
			for (int j = 0; j < 4; j++) begin
				for (int i = 0; i < 3; i++)
					prod_s2[i][j] <= $signed(p_s1[i]) * mat_entry(mat, i, j);
				tr_s2[j] <= mat_entry(mat, 3, j);
				sum_s3[j] <= SUM_W'(prod_s2[0][j]) + SUM_W'(prod_s2[1][j])
					+ SUM_W'(prod_s2[2][j]) + (SUM_W'(tr_s2[j]) <<< 16);
			end
		end
	end

	always_comb begin
		for (int j = 0; j < 4; j++)
			nr[j] = narrow(sum_s3[j]);
	end

	assign push = en && v_s3;
	always_comb begin
		push_item.cmd = cmd_s3;
		push_item.sat = nr[0][32] | nr[1][32] | nr[2][32] | nr[3][32];
		push_item.x   = nr[0][31:0];
		push_item.y   = nr[1][31:0];
		push_item.z   = nr[2][31:0];
		push_item.w   = nr[3][31:0];
	end

endmodule

@@ sv/vt4_queue.sv @@
// Short FIFO between front and back parts.
// Depends on vt4_pkg.
module vt4_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vt4_pkg::item_t    push_item,
	input  logic              pop,
	output vt4_pkg::item_t    head,
	output vt4_pkg::q_stat_t  stat
);
	import vt4_pkg::*;

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

@@ sv/vt4_back.sv @@
// Back part: bit-per-stage divide pipeline for x, y, z by w and output register.
// Depends on vt4_pkg; pops items from vt4_queue.
module vt4_back (
	input  logic               clk,
	input  logic               arst_n,
	input  vt4_pkg::q_stat_t   q_stat,
	input  vt4_pkg::item_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic signed [31:0] z_out,
	output logic signed [31:0] w_out,
	output logic               saturated,
	output logic               divide_by_zero
);
	import vt4_pkg::*;

	logic               en;
	logic               v_s   [QBITS+1];
	item_t              it_s  [QBITS+1];
	logic [31:0]        ud_s  [QBITS+1];
	logic [2:0]         neg_s [QBITS+1];
	logic [31:0]        rem_s [QBITS+1][3];
	logic [QBITS-1:0]   quo_s [QBITS+1][3];
	logic signed [31:0] num   [3];
	logic signed [31:0] hnum  [3];
	logic signed [31:0] res   [3];
	logic               lsat  [3];
	logic               dz;
	logic               out_valid_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_stat.empty;

	assign hnum[0] = head.x;
	assign hnum[1] = head.y;
	assign hnum[2] = head.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QBITS; k++)
				v_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= !q_stat.empty;
			for (int k = 1; k <= QBITS; k++)
				v_s[k] <= v_s[k-1];
			out_valid_q <= v_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s[0] <= head;
			ud_s[0] <= head.w[31] ? 32'(-head.w) : head.w;
			for (int j = 0; j < 3; j++) begin
				neg_s[0][j]  <= hnum[j][31] ^ head.w[31];
				rem_s[0][j]  <= '0;
				quo_s[0][j]  <= {(hnum[j][31] ? 32'(-hnum[j]) : hnum[j]), 16'h0};
			end
		end
	end

	for (genvar k = 1; k <= QBITS; k++) begin : g_div
		logic [32:0] trial [3];
		always_comb begin
			for (int j = 0; j < 3; j++)
				trial[j] = {rem_s[k-1][j], quo_s[k-1][j][QBITS-1]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				it_s[k]  <= it_s[k-1];
				ud_s[k]  <= ud_s[k-1];
				neg_s[k] <= neg_s[k-1];
				for (int j = 0; j < 3; j++) begin
					if (trial[j] >= {1'b0, ud_s[k-1]}) begin
						rem_s[k][j] <= 32'(trial[j] - {1'b0, ud_s[k-1]});
						quo_s[k][j] <= {quo_s[k-1][j][QBITS-2:0], 1'b1};
					end else begin
						rem_s[k][j] <= trial[j][31:0];
						quo_s[k][j] <= {quo_s[k-1][j][QBITS-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign num[0] = it_s[QBITS].x;
	assign num[1] = it_s[QBITS].y;
	assign num[2] = it_s[QBITS].z;

	always_comb begin
		dz = (it_s[QBITS].cmd == CMD_DIVIDE) && (ud_s[QBITS] == '0);
		for (int j = 0; j < 3; j++) begin
			lsat[j] = 1'b0;
			res[j]  = num[j];
			if (it_s[QBITS].cmd == CMD_DIVIDE) begin
				if (ud_s[QBITS] == '0) begin
					if (num[j] > 0) begin
						res[j]  = Q_MAX;
						lsat[j] = 1'b1;
					end else if (num[j] < 0) begin
						res[j]  = Q_MIN;
						lsat[j] = 1'b1;
					end else begin
						res[j] = '0;
					end
				end else if (neg_s[QBITS][j]) begin
					if (quo_s[QBITS][j] > QBITS'(64'h8000_0000)) begin
						res[j]  = Q_MIN;
						lsat[j] = 1'b1;
					end else begin
						res[j] = 32'(-quo_s[QBITS][j][31:0]);
					end
				end else begin
					if (quo_s[QBITS][j] > QBITS'(64'h7FFF_FFFF)) begin
						res[j]  = Q_MAX;
						lsat[j] = 1'b1;
					end else begin
						res[j] = quo_s[QBITS][j][31:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out          <= res[0];
			y_out          <= res[1];
			z_out          <= res[2];
			w_out          <= it_s[QBITS].w;
			saturated      <= it_s[QBITS].sat | lsat[0] | lsat[1] | lsat[2];
			divide_by_zero <= dz;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/vertex_transform_4x4_top.sv @@
// Top level of the 4x4 vertex transform with perspective divide.
// Depends on vt4_pkg, vt4_front, vt4_queue, vt4_back.
//
//   channel  direction  signals
//   cfg      in         cfg_valid/cfg_ready, cfg_index, cfg_data
//   in       in         in_valid/in_ready, command, x_in, y_in, z_in
//   out      out        out_valid/out_ready, x_out..w_out, saturated, divide_by_zero
//
// One vertex per cycle sustained unless the output stalls. Path: multiply-add front
// registers s1 to s3, queue storage, divider (an entry stage, then one quotient bit
// per stage), output register. arst_n loads the identity matrix and empties all
// stages. A stalled output freezes the divider; the 4-entry queue holds the front.
module vertex_transform_4x4_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vt4_pkg::IDX_W-1:0]  cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic signed [31:0]         x_in,
	input  logic signed [31:0]         y_in,
	input  logic signed [31:0]         z_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         x_out,
	output logic signed [31:0]         y_out,
	output logic signed [31:0]         z_out,
	output logic signed [31:0]         w_out,
	output logic                       saturated,
	output logic                       divide_by_zero
);
	import vt4_pkg::*;

	mat_t    mat_q;
	q_stat_t q_stat;
	logic    push, pop;
	item_t   push_item, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= {RST_ROW4_HI, 64'h0, RST_ROW3_HI, 64'h0,
				64'h0, RST_ROW2_LO, 64'h0, RST_ROW1_LO};
		end else if (cfg_valid && cfg_index < IDX_W'(NREGS)) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	vt4_front u_front (
		.clk, .arst_n, .mat(mat_q), .in_valid, .in_ready, .command,
		.x_in, .y_in, .z_in, .q_stat, .push, .push_item
	);

	vt4_queue u_queue (
		.clk, .arst_n, .push, .push_item, .pop, .head, .stat(q_stat)
	);

	vt4_back u_back (
		.clk, .arst_n, .q_stat, .head, .pop, .out_valid, .out_ready,
		.x_out, .y_out, .z_out, .w_out, .saturated, .divide_by_zero
	);

endmodule

@@ sv/vt4_checker.sv @@
// Port-level checks for vertex_transform_4x4_top, bound to the top level.
// Depends on vertex_transform_4x4_top_defines.svh.
`include "vertex_transform_4x4_top_defines.svh"

module vt4_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] x_out,
	input logic signed [31:0] w_out,
	input logic               saturated,
	input logic               divide_by_zero
);
	`VT4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(x_out), "out beat dropped or changed while stalled")
	`VT4_ASSERT_NOW(a_dz_w_zero, out_valid && divide_by_zero, w_out == 0, "divide_by_zero with nonzero w")
	`VT4_ASSERT_NOW(a_dz_sat, out_valid && divide_by_zero && x_out != 0, saturated, "zero-w clip without saturated")
	`VT4_ASSERT_NOW(a_dz_clip, out_valid && divide_by_zero, x_out == 0 || x_out == 32'sh7FFF_FFFF || x_out == 32'sh8000_0000, "zero-w result not clipped")
endmodule

bind vertex_transform_4x4_top vt4_checker u_vt4_checker (
	.clk, .arst_n, .out_valid, .out_ready, .x_out, .w_out, .saturated, .divide_by_zero
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for vertex_transform_4x4_top: a 4x4 Q16.16 point transform with an optional divide by w.
// Predicts each result from its own copy of the matrix and checks every output beat.
// Depends on vt4_pkg and the RTL; stands alone otherwise.
module testbench;
	import vt4_pkg::*;

	typedef struct {
		logic [31:0] x, y, z, w;
		logic        sat, dz;
	} vtx_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [63:0]         cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic signed [31:0]  x_in, y_in, z_in;
	logic                out_valid;
	logic                out_ready;
	logic signed [31:0]  x_out, y_out, z_out, w_out;
	logic                saturated;
	logic                divide_by_zero;

	logic [63:0]  matrix [NREGS];
	vtx_result_t  pending [$];
	int           mismatches;
	int           gap_next;
	int           stall_left;
	bit           idle_on;
	longint       cycles;

	localparam int SETTLE = 64;
	localparam longint CYCLE_LIMIT = 400000;

	vertex_transform_4x4_top dut (.*);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	// magnitude to Q16.16 with clipping; returns {sat, value}
	function automatic logic [32:0] clip_q(input bit neg, input logic [127:0] mag);
		logic [31:0] t;
		t = mag[31:0];
		if (neg) begin
			if (mag > 128'h8000_0000)
				return {1'b1, Q_MIN};
			return {1'b0, -t};
		end
		if (mag > 128'h7FFF_FFFF)
			return {1'b1, Q_MAX};
		return {1'b0, t};
	endfunction

	function automatic logic signed [31:0] coef(input int r, input int c);
		logic [63:0] rv;
		rv = matrix[r*2 + c/2];
		return (c % 2) ? rv[63:32] : rv[31:0];
	endfunction

	function automatic vtx_result_t transform_vertex(input cmd_t c,
			input logic signed [31:0] x, y, z);
		logic signed [127:0] acc, a, b;
		logic signed [31:0]  p [3];
		logic [31:0]         r [4];
		logic [32:0]         q;
		logic [63:0]         un, ud;
		logic signed [31:0]  n, d;
		vtx_result_t         res;
		res.sat = 1'b0;
		p[0] = x; p[1] = y; p[2] = z;
		for (int j = 0; j < 4; j++) begin
			a = coef(3, j);
			acc = a * 128'sd65536;
			for (int i = 0; i < 3; i++) begin
				a = p[i];
				b = coef(i, j);
				acc = acc + a * b;
			end
			q = clip_q(acc < 0, (acc < 0 ? -acc : acc) >> 16);
			res.sat |= q[32];
			r[j] = q[31:0];
		end
		res.dz = (c == CMD_DIVIDE) && (r[3] == 0);
		if (c == CMD_DIVIDE) begin
			d = r[3];
			for (int j = 0; j < 3; j++) begin
				n = r[j];
				if (d == 0) begin
					if (n != 0) begin
						res.sat = 1'b1;
						r[j] = (n > 0) ? Q_MAX : Q_MIN;
					end
				end else begin
					un = (n < 0) ? -64'(n) : 64'(n);
					ud = (d < 0) ? -64'(d) : 64'(d);
					q = clip_q((n < 0) != (d < 0), 128'((un << 16) / ud));
					res.sat |= q[32];
					r[j] = q[31:0];
				end
			end
		end
		res.x = r[0]; res.y = r[1]; res.z = r[2]; res.w = r[3];
		return res;
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			2: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
			default: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
		endcase
	endfunction

	task automatic send_vertex(input cmd_t c, input logic [31:0] x, y, z);
		repeat (gap_next) @(posedge clk);
		in_valid <= 1'b1;
		command  <= c;
		x_in     <= x;
		y_in     <= y;
		z_in     <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending.push_back(transform_vertex(c, x, y, z));
		gap_next = idle_on ? $urandom_range(0, 8) : 0;
		if (gap_next > 0)
			in_valid <= 1'b0;
	endtask

	task automatic drain();
		if (gap_next == 0)
			in_valid <= 1'b0;
		gap_next = 0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// block must be idle; index beyond 7 must leave the matrix alone
	task automatic write_matrix(input logic [63:0] vals [NREGS]);
		for (int i = 0; i <= NREGS; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == NREGS) ? IDX_W'($urandom_range(NREGS, 15)) : IDX_W'(i);
			cfg_data  <= (i == NREGS) ? {$urandom, $urandom} : vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (i < NREGS)
				matrix[i] = vals[i];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_identity_extremes();
		logic [31:0] v [6];
		v = '{32'h0, Q_MAX, Q_MIN, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};
		idle_on = 1'b0;
		for (int i = 0; i < 6; i++) begin
			send_vertex(CMD_PLAIN, v[i], v[(i+1)%6], v[(i+2)%6]);
			send_vertex(CMD_DIVIDE, v[i], v[(i+2)%6], v[(i+4)%6]);
		end
		drain();
	endtask

	task automatic test_saturation();
		logic [63:0] m [NREGS];
		idle_on = 1'b1;
		m = '{default: {Q_MAX, Q_MAX}};
		write_matrix(m);
		send_vertex(CMD_PLAIN, Q_MAX, Q_MAX, Q_MAX);
		send_vertex(CMD_DIVIDE, Q_MIN, Q_MAX, 32'h0);
		drain();
		m = '{default: {Q_MIN, Q_MIN}};
		write_matrix(m);
		send_vertex(CMD_PLAIN, Q_MIN, Q_MIN, Q_MIN);
		send_vertex(CMD_DIVIDE, Q_MIN, Q_MIN, Q_MIN);
		drain();
	endtask

	task automatic test_zero_w();
		logic [63:0] m [NREGS];
		// w column all zero: divide hits zero w for positive, negative, zero numerators
		m = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
			64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0};
		write_matrix(m);
		send_vertex(CMD_DIVIDE, 32'h0002_0000, 32'hFFFE_0000, 32'h0);
		send_vertex(CMD_DIVIDE, 32'h0, 32'h0, 32'h0);
		send_vertex(CMD_PLAIN, 32'h0003_0000, 32'hFFFF_8000, 32'h0000_0001);
		drain();
		// tiny w: quotient overflows
		m[7] = {32'h0000_0001, 32'h0};
		write_matrix(m);
		send_vertex(CMD_DIVIDE, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0001);
		drain();
		m[7] = {32'hFFFF_FFFF, 32'h0};
		write_matrix(m);
		send_vertex(CMD_DIVIDE, 32'h0100_0000, 32'hFF00_0000, 32'h0);
		drain();
	endtask

	task automatic test_random_stream();
		logic [63:0] m [NREGS];
		for (int ph = 0; ph < 8; ph++) begin
			foreach (m[i])
				m[i] = {rand_q(), rand_q()};
			write_matrix(m);
			idle_on = (ph % 3) != 0;
			for (int n = 0; n < 235; n++) begin
				send_vertex(cmd_t'($urandom_range(0, 1)), rand_q(), rand_q(), rand_q());
				if (ph == 4 && n == 100) begin
					drain();
				end
			end
			drain();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vtx_result_t e;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat x=%h", x_out);
				end else begin
					e = pending.pop_front();
					if (x_out !== e.x || y_out !== e.y || z_out !== e.z || w_out !== e.w
							|| saturated !== e.sat || divide_by_zero !== e.dz) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %h %h %h %h s%b d%b got %h %h %h %h s%b d%b",
								e.x, e.y, e.z, e.w, e.sat, e.dz,
								x_out, y_out, z_out, w_out, saturated, divide_by_zero);
					end
				end
				stall_left = idle_on ? $urandom_range(0, 8) : 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		command   <= 1'b0;
		x_in      <= '0;
		y_in      <= '0;
		z_in      <= '0;
		mismatches = 0;
		gap_next   = 0;
		idle_on    = 1'b0;
		cycles     = 0;
		matrix = '{RST_ROW1_LO, 64'h0, RST_ROW2_LO, 64'h0, 64'h0, RST_ROW3_HI, 64'h0, RST_ROW4_HI};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_saturation();
		test_zero_w();
		test_random_stream();
		drain();
		if (mismatches == 0 && pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
